/* rtl/core/bbra_pkg.sv */
`timescale 1ns / 1ps

package bbra_pkg;

  localparam int NUM_CH   = 4;
  localparam int CH_W     = 8;
  localparam int IN_W     = 32;
  localparam int WIN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RECIP_W  = 33;
  localparam int STEP_W   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE   = 2'd1;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 33'd65536;
  localparam logic [STEP_W-1:0]  STEP_FIRST  = 6'd32;
  localparam logic [STEP_W-1:0]  BIT_NARROW  = 6'd16;
  localparam logic [STEP_W-1:0]  BIT_WIDE    = 6'd32;

  typedef struct packed {
    logic load_sum;
    logic clear;
    logic load_prod;
  } lane_ctrl_t;

endpackage

/* rtl/core/bbra_recip.sv */
`timescale 1ns / 1ps

module bbra_recip (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bbra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbra_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             wide,
  output logic [bbra_pkg::RECIP_W-1:0]     recip,
  output logic                             busy
);
  import bbra_pkg::*;

  logic [WIN_W-1:0]   window;
  logic               pending;
  logic               running;
  logic [STEP_W-1:0]  step;
  logic [WIN_W-1:0]   rem;
  logic [RECIP_W-1:0] quo;

  logic               cfg_hit;
  logic [WIN_W:0]     divisor;
  logic               num_bit;
  logic [WIN_W:0]     rem_sh;
  logic               q_bit;
  logic [WIN_W-1:0]   rem_next;
  logic [RECIP_W-1:0] quo_next;

  assign cfg_hit = cfg_we && (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_WIDE_MODE);
  assign divisor = (window == '0) ? (WIN_W+1)'(1) : {1'b0, window};
  assign num_bit = (step == (wide ? BIT_WIDE : BIT_NARROW));
  assign rem_sh  = {rem, num_bit};
  assign q_bit   = (rem_sh >= divisor);
  assign rem_next = q_bit ? WIN_W'(rem_sh - divisor) : rem_sh[WIN_W-1:0];
  assign quo_next = {quo[RECIP_W-2:0], q_bit};
  assign busy = pending || running;

  always_ff @(posedge clk) begin
    if (rst) begin
      window  <= WIN_W'(1);
      wide    <= 1'b0;
      recip   <= RECIP_RESET;
      pending <= 1'b0;
      running <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_WINDOW_SIZE) begin
        window <= cfg_data[WIN_W-1:0];
      end
      if (cfg_we && cfg_index == REG_WIDE_MODE) begin
        wide <= cfg_data[0];
      end
      if (cfg_hit) begin
        pending <= 1'b1;
      end else if (pending) begin
        pending <= 1'b0;
        running <= 1'b1;
      end else if (running && step == '0) begin
        running <= 1'b0;
        recip   <= quo_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      step <= STEP_FIRST;
      rem  <= '0;
      quo  <= '0;
    end else if (running) begin
      step <= step - STEP_W'(1);
      rem  <= rem_next;
      quo  <= quo_next;
    end
  end

endmodule

/* rtl/core/bbra_lane.sv */
`timescale 1ns / 1ps

module bbra_lane #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bbra_pkg::lane_ctrl_t          ctrl,
  input  logic                          wide,
  input  logic [bbra_pkg::IN_W-1:0]     enter,
  input  logic [bbra_pkg::IN_W-1:0]     leave,
  input  logic [bbra_pkg::RECIP_W-1:0]  recip,
  output logic [SUM_WIDTH+31:0]         prod
);
  import bbra_pkg::*;

  localparam logic [SUM_WIDTH-1:0] NARROW_MASK = SUM_WIDTH'(17'h0FFFF);

  logic [SUM_WIDTH-1:0]    sum;
  logic [SUM_WIDTH-1:0]    base;
  logic [SUM_WIDTH-1:0]    raw;
  logic [SUM_WIDTH-1:0]    sum_next;
  logic [SUM_WIDTH+31:0]   prod_next;

  assign base     = ctrl.clear ? '0 : sum;
  assign raw      = base + enter[SUM_WIDTH-1:0] - leave[SUM_WIDTH-1:0];
  assign sum_next = wide ? raw : (raw & NARROW_MASK);
  assign prod_next = recip[RECIP_W-1] ? {sum, 32'd0}
                                      : ((SUM_WIDTH+32)'(sum) *
                                         (SUM_WIDTH+32)'(recip[31:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.load_sum) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      prod <= prod_next;
    end
  end

endmodule

/* rtl/core/bbra_merge.sv */
`timescale 1ns / 1ps

module bbra_merge #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       load,
  input  logic                                       wide,
  input  logic [bbra_pkg::NUM_CH-1:0][SUM_WIDTH+31:0] prods,
  output logic [bbra_pkg::NUM_CH*bbra_pkg::CH_W-1:0] pixel
);
  import bbra_pkg::*;

  localparam int AVG_W = SUM_WIDTH + 16;

  logic [NUM_CH-1:0][CH_W-1:0] avg8;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [AVG_W-1:0] avg;
    assign avg = wide ? AVG_W'(prods[c][SUM_WIDTH+31:32]) : prods[c][SUM_WIDTH+31:16];
    assign avg8[c] = (|avg[AVG_W-1:CH_W]) ? {CH_W{1'b1}} : avg[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel <= avg8;
    end
  end

endmodule

/* rtl/core/box_blur_running_average.sv */
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// in        in_valid / in_stall     start_line, enter_*, leave_*
// out       out_valid / out_stall   blurred_pixel
// cfg       cfg_we                  cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each passes sum, multiply, pack.
// A write to window_size or wide_mode reruns the reciprocal divider, one
// quotient bit a cycle; in_stall is high until the divider is done.
// Reset is synchronous; it clears the running sums and loads window one.
// Each stage moves on whenever the next one is empty or moving; input waits on the divider.

module box_blur_running_average #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bbra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             start_line,
  input  logic [bbra_pkg::IN_W-1:0]        enter_blue,
  input  logic [bbra_pkg::IN_W-1:0]        enter_green,
  input  logic [bbra_pkg::IN_W-1:0]        enter_red,
  input  logic [bbra_pkg::IN_W-1:0]        enter_alpha,
  input  logic [bbra_pkg::IN_W-1:0]        leave_blue,
  input  logic [bbra_pkg::IN_W-1:0]        leave_green,
  input  logic [bbra_pkg::IN_W-1:0]        leave_red,
  input  logic [bbra_pkg::IN_W-1:0]        leave_alpha,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      blurred_pixel
);
  import bbra_pkg::*;

  logic                               wide;
  logic [RECIP_W-1:0]                 recip;
  logic                               busy;
  logic                               v1;
  logic                               v2;
  logic                               acc;
  logic                               adv1;
  logic                               adv2;
  lane_ctrl_t                         ctrl;
  logic [NUM_CH-1:0][IN_W-1:0]        enters;
  logic [NUM_CH-1:0][IN_W-1:0]        leaves;
  logic [NUM_CH-1:0][SUM_WIDTH+31:0]  prods;

  assign enters = {enter_alpha, enter_red, enter_green, enter_blue};
  assign leaves = {leave_alpha, leave_red, leave_green, leave_blue};

  assign adv2     = v2 && (!out_valid || !out_stall);
  assign adv1     = v1 && (!v2 || adv2);
  assign in_stall = busy || (v1 && !adv1);
  assign acc      = in_valid && !in_stall;

  assign ctrl.load_sum  = acc;
  assign ctrl.clear     = start_line;
  assign ctrl.load_prod = adv1;

  bbra_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wide      (wide),
    .recip     (recip),
    .busy      (busy)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    bbra_lane #(
      .SUM_WIDTH (SUM_WIDTH)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .wide  (wide),
      .enter (enters[c]),
      .leave (leaves[c]),
      .recip (recip),
      .prod  (prods[c])
    );
  end

  bbra_merge #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_merge (
    .clk   (clk),
    .load  (adv2),
    .wide  (wide),
    .prods (prods),
    .pixel (blurred_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
